// ===== rtl/gspc_pkg.sv =====
// shared types, codes and constants of the gauge stepper position controller
package gspc_pkg;

    // command codes carried in the input tuser
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET_POS = 2'd1,
        CMD_STOP    = 2'd2,
        CMD_HOME    = 2'd3
    } cmd_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MIN_VALUE  = 2'd0,
        REG_MAX_VALUE  = 2'd1,
        REG_FULL_STEPS = 2'd2,
        REG_STEP_DELAY = 2'd3
    } reg_idx_t;

    localparam int CFG_ADDR_BITS  = 2;
    localparam int CMD_BITS       = 2;
    localparam int COIL_BITS      = 4;
    localparam int MIN_VALUE_RST  = 0;
    localparam int MAX_VALUE_RST  = 100;
    localparam int FULL_STEPS_RST = 600;
    localparam int STEP_DELAY_RST = 1;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REL,
        ST_MAP_MUL,
        ST_MAP_START,
        ST_MAP_DIV,
        ST_RB_MUL,
        ST_RB_START,
        ST_RB_DIV,
        ST_FIN
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic rel_load;
        logic map_mul;
        logic map_start;
        logic map_wb;
        logic rb_mul;
        logic rb_start;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic map_req;
        logic div_busy;
        logic out_free;
    } ctrl_stat_t;

    // full-step coil pattern, bits a1,a2,b1,b2 from bit 3 down
    function automatic logic [3:0] phase_coils(input logic [1:0] idx);
        logic [3:0] pat;
        case (idx)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b0101;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/gspc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module gspc_div #(
    parameter int DW = 33,
    parameter int VW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    dvs_reg;
    logic [VW:0]      rem_sh;
    logic [VW:0]      rem_sub;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DW-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!rem_sub[VW]) begin
                rem_reg <= rem_sub[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/gspc_datapath.sv =====
// datapath: config registers, needle state, multiplier, divider, output register
module gspc_datapath #(
    parameter int SB = 16,
    parameter int VB = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [gspc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [((SB > VB) ? SB : VB)-1:0]  cfg_wdata,
    input  logic [gspc_pkg::CMD_BITS-1:0]     in_cmd,
    input  logic signed [VB-1:0]              in_value,
    input  gspc_pkg::ctrl_cmd_t               cmd,
    output gspc_pkg::ctrl_stat_t              stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [gspc_pkg::COIL_BITS-1:0]    out_coils,
    output logic [SB-1:0]                     out_step,
    output logic signed [VB-1:0]              out_position,
    output logic                              out_homed,
    output logic                              out_moving,
    output logic                              out_ignored
);

    localparam int DW  = SB + VB + 1;
    localparam int DVW = (SB > VB) ? SB : VB;
    localparam int PW  = SB + VB;

    // configuration
    logic signed [VB-1:0] min_reg;
    logic signed [VB-1:0] max_reg;
    logic [SB-1:0]        fs_reg;
    logic [SB-1:0]        sd_reg;

    // needle state
    logic [SB-1:0]                  cur_reg;
    logic [SB-1:0]                  tgt_reg;
    logic                           homed_reg;
    logic [SB-1:0]                  delay_reg;
    logic [gspc_pkg::COIL_BITS-1:0] coil_reg;
    logic                           ign_reg;

    // working registers
    logic signed [VB-1:0] value_reg;
    logic [VB-1:0]        rel_reg;
    logic [PW-1:0]        prod_reg;

    // output register
    logic                           ovalid_reg;
    logic [gspc_pkg::COIL_BITS-1:0] ocoils_reg;
    logic [SB-1:0]                  ostep_reg;
    logic signed [VB-1:0]           opos_reg;
    logic                           ohomed_reg;
    logic                           omoving_reg;
    logic                           oign_reg;

    logic signed [VB:0]   range_s;
    logic                 range_pos;
    logic [VB-1:0]        range_u;
    logic [VB-1:0]        rel_c;
    logic [SB:0]          cur_inc;
    logic [SB-1:0]        cur_dec;
    logic                 div_start;
    logic [DW-1:0]        div_dividend;
    logic [DVW-1:0]       div_divisor;
    logic                 div_busy;
    logic [DW-1:0]        div_quo;
    logic signed [VB-1:0] pos_c;
    logic [SB-1:0]        tgt_map;
    gspc_pkg::cmd_t       in_cmd_e;

    assign in_cmd_e = gspc_pkg::cmd_t'(in_cmd);

    // user range and clamped offset of the requested value
    always_comb begin
        range_s   = (VB + 1)'(max_reg) - (VB + 1)'(min_reg);
        range_pos = !range_s[VB] && (range_s != '0);
        range_u   = range_s[VB-1:0];
        if (value_reg < min_reg) begin
            rel_c = '0;
        end else if (value_reg > max_reg) begin
            rel_c = range_u;
        end else begin
            rel_c = VB'(value_reg - min_reg);
        end
    end

    assign cur_inc = (SB + 1)'(cur_reg) + 1'b1;
    assign cur_dec = cur_reg - SB'(1);

    // divider operands: rounded map to steps, or rounded readback to user units
    always_comb begin
        div_start = cmd.map_start || cmd.rb_start;
        if (cmd.map_start) begin
            div_dividend = DW'(prod_reg) + DW'(range_u >> 1);
            div_divisor  = DVW'(range_u);
        end else begin
            div_dividend = DW'(prod_reg) + DW'(fs_reg >> 1);
            div_divisor  = DVW'(fs_reg);
        end
    end

    gspc_div #(
        .DW(DW),
        .VW(DVW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // quotient post-processing
    always_comb begin
        if (div_quo > DW'(fs_reg)) begin
            tgt_map = fs_reg;
        end else begin
            tgt_map = div_quo[SB-1:0];
        end
        if (!range_pos) begin
            pos_c = min_reg;
        end else if (div_quo > DW'(range_u)) begin
            pos_c = max_reg;
        end else begin
            pos_c = min_reg + $signed(div_quo[VB-1:0]);
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= VB'(gspc_pkg::MIN_VALUE_RST);
            max_reg <= VB'(gspc_pkg::MAX_VALUE_RST);
            fs_reg  <= SB'(gspc_pkg::FULL_STEPS_RST);
            sd_reg  <= SB'(gspc_pkg::STEP_DELAY_RST);
        end else if (cfg_we) begin
            unique case (gspc_pkg::reg_idx_t'(cfg_addr))
                gspc_pkg::REG_MIN_VALUE:  min_reg <= cfg_wdata[VB-1:0];
                gspc_pkg::REG_MAX_VALUE:  max_reg <= cfg_wdata[VB-1:0];
                gspc_pkg::REG_FULL_STEPS: begin
                    if (cfg_wdata[SB-1:0] != '0) begin
                        fs_reg <= cfg_wdata[SB-1:0];
                    end
                end
                gspc_pkg::REG_STEP_DELAY: begin
                    if (cfg_wdata[SB-1:0] == '0) begin
                        sd_reg <= SB'(1);
                    end else begin
                        sd_reg <= cfg_wdata[SB-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // needle state: command at the accepted beat, map result on write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg   <= '0;
            tgt_reg   <= '0;
            homed_reg <= 1'b0;
            delay_reg <= '0;
            coil_reg  <= '0;
            ign_reg   <= 1'b0;
        end else if (cmd.accept) begin
            ign_reg <= (in_cmd_e == gspc_pkg::CMD_SET_POS) && !homed_reg;
            case (in_cmd_e)
                gspc_pkg::CMD_TICK: begin
                    if (tgt_reg == cur_reg) begin
                        delay_reg <= '0;
                        if (!homed_reg) begin
                            homed_reg <= 1'b1;
                            tgt_reg   <= '0;
                            cur_reg   <= '0;
                        end
                    end else if (delay_reg != '0) begin
                        delay_reg <= delay_reg - 1'b1;
                    end else begin
                        delay_reg <= sd_reg - 1'b1;
                        if (tgt_reg > cur_reg) begin
                            coil_reg <= gspc_pkg::phase_coils(cur_inc[1:0]);
                            if (cur_inc > (SB + 1)'(fs_reg)) begin
                                cur_reg <= fs_reg;
                            end else begin
                                cur_reg <= cur_inc[SB-1:0];
                            end
                        end else begin
                            coil_reg <= gspc_pkg::phase_coils(cur_dec[1:0]);
                            cur_reg  <= cur_dec;
                        end
                    end
                end
                gspc_pkg::CMD_STOP: begin
                    tgt_reg <= cur_reg;
                end
                gspc_pkg::CMD_HOME: begin
                    coil_reg <= gspc_pkg::phase_coils(2'd0);
                    cur_reg  <= fs_reg;
                    // min_value always maps to step zero
                    if (range_pos) begin
                        tgt_reg <= '0;
                    end
                end
                default: ;
            endcase
        end else if (cmd.map_wb) begin
            tgt_reg <= tgt_map;
        end
    end

    // working registers: latched value, clamped offset, product
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            value_reg <= in_value;
        end
        if (cmd.rel_load) begin
            rel_reg <= rel_c;
        end
        if (cmd.map_mul) begin
            prod_reg <= PW'(rel_reg) * PW'(fs_reg);
        end else if (cmd.rb_mul) begin
            prod_reg <= PW'(cur_reg) * PW'(range_u);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            ocoils_reg  <= coil_reg;
            ostep_reg   <= cur_reg;
            opos_reg    <= pos_c;
            ohomed_reg  <= homed_reg;
            omoving_reg <= tgt_reg != cur_reg;
            oign_reg    <= ign_reg;
        end
    end

    // status toward the controller
    always_comb begin
        stat.map_req  = (in_cmd_e == gspc_pkg::CMD_SET_POS) && homed_reg && range_pos;
        stat.div_busy = div_busy;
        stat.out_free = !ovalid_reg || out_ready;
    end

    assign out_valid    = ovalid_reg;
    assign out_coils    = ocoils_reg;
    assign out_step     = ostep_reg;
    assign out_position = opos_reg;
    assign out_homed    = ohomed_reg;
    assign out_moving   = omoving_reg;
    assign out_ignored  = oign_reg;

endmodule

// ===== rtl/gspc_ctrl.sv =====
// controller state machine sequencing map and readback through the shared divider
module gspc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  gspc_pkg::ctrl_stat_t stat,
    output gspc_pkg::ctrl_cmd_t  cmd
);

    gspc_pkg::state_t state_reg;
    gspc_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gspc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            gspc_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = stat.map_req ? gspc_pkg::ST_REL : gspc_pkg::ST_RB_MUL;
                end
            end
            gspc_pkg::ST_REL: begin
                cmd.rel_load = 1'b1;
                state_next   = gspc_pkg::ST_MAP_MUL;
            end
            gspc_pkg::ST_MAP_MUL: begin
                cmd.map_mul = 1'b1;
                state_next  = gspc_pkg::ST_MAP_START;
            end
            gspc_pkg::ST_MAP_START: begin
                cmd.map_start = 1'b1;
                state_next    = gspc_pkg::ST_MAP_DIV;
            end
            gspc_pkg::ST_MAP_DIV: begin
                if (!stat.div_busy) begin
                    cmd.map_wb = 1'b1;
                    state_next = gspc_pkg::ST_RB_MUL;
                end
            end
            gspc_pkg::ST_RB_MUL: begin
                cmd.rb_mul = 1'b1;
                state_next = gspc_pkg::ST_RB_START;
            end
            gspc_pkg::ST_RB_START: begin
                cmd.rb_start = 1'b1;
                state_next   = gspc_pkg::ST_RB_DIV;
            end
            gspc_pkg::ST_RB_DIV: begin
                if (!stat.div_busy) begin
                    state_next = gspc_pkg::ST_FIN;
                end
            end
            gspc_pkg::ST_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = gspc_pkg::ST_IDLE;
                end
            end
            default: state_next = gspc_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/gauge_stepper_position_controller_core.sv =====
// top level of the gauge stepper position controller
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tuser: cmd, s_tdata: value
//  m_       out  m_tvalid/m_tready    m_tdata: coils, step_now, position, homed, moving, ignored
//  cfg_     in   cfg_we               cfg_addr: register index, cfg_wdata: value
//
// a tick, stop or homing beat takes one pass of the bit-serial divider; a set on a homed gauge
// with a non-empty range takes two passes, a map pass and then a readback pass
// (one quotient bit per cycle over STEP_BITS+VALUE_BITS+1 bits).
// one beat is in flight at a time; the next is taken once the result sits in the output register.
// a stalled result holds the output register; a finished beat waits for it to drain.
// reset is synchronous and active low; config registers return to their defaults.
module gauge_stepper_position_controller_core #(
    parameter int STEP_BITS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [gspc_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [((STEP_BITS > VALUE_BITS) ? STEP_BITS : VALUE_BITS)-1:0] cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // value
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
    // cmd
    input  logic [gspc_pkg::CMD_BITS-1:0]         s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // coils, step_now, position, homed, moving, ignored
    output logic [((STEP_BITS + VALUE_BITS + 7 + 7) / 8) * 8-1:0] m_tdata
);

    localparam int OFW      = gspc_pkg::COIL_BITS + STEP_BITS + VALUE_BITS + 3;
    localparam int OTW      = ((STEP_BITS + VALUE_BITS + 7 + 7) / 8) * 8;
    localparam int HOMED_B  = gspc_pkg::COIL_BITS + STEP_BITS + VALUE_BITS;
    localparam int IGNORE_B = HOMED_B + 2;

    gspc_pkg::ctrl_cmd_t  cmd;
    gspc_pkg::ctrl_stat_t stat;

    logic [gspc_pkg::COIL_BITS-1:0] coils;
    logic [STEP_BITS-1:0]           step_now;
    logic signed [VALUE_BITS-1:0]   position;
    logic                           homed;
    logic                           moving;
    logic                           ignored;

    gspc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gspc_datapath #(
        .SB(STEP_BITS),
        .VB(VALUE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_cmd       (s_tuser),
        .in_value     (s_tdata[VALUE_BITS-1:0]),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_coils    (coils),
        .out_step     (step_now),
        .out_position (position),
        .out_homed    (homed),
        .out_moving   (moving),
        .out_ignored  (ignored)
    );

    // result beat packing, coils in the lowest bits
    assign m_tdata = OTW'({ignored, moving, homed, position, step_now, coils});

    // one beat at a time: no second accept right after an accept
    a_single_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a beat is in flight");

    // a new result is only loaded while the input side is closed
    a_load_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result loaded while input side open");

    // a rejected set position only happens on an unhomed gauge
    a_ignored_unhomed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[IGNORE_B]) |-> !m_tdata[HOMED_B])
        else $error("set position rejected on a homed gauge");

    // result packing covers all fields
    a_pack_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (OFW <= OTW))
        else $error("result fields exceed tdata width");

endmodule

// ===== bench/tb_top.sv =====
// testbench for the gauge stepper position controller: predicted needle reports vs. the block
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    // phase patterns 0..3 from the low nibble up: 1010, 0110, 0101, 1001
    localparam logic [15:0] COIL_SEQ = 16'h956A;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        gspc_pkg::cmd_t cmd;
        logic [15:0]    value;
    } gauge_cmd_t;

    typedef struct packed {
        logic [3:0]  coils;
        logic [15:0] step_now;
        logic [15:0] position;
        logic        homed;
        logic        moving;
        logic        ignored;
    } gauge_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // value
    logic [15:0] s_tdata = '0;
    // cmd
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // coils, step_now, position, homed, moving, ignored
    logic [39:0] m_tdata;

    gauge_cmd_t    command_q[$];
    gauge_report_t report_q[$];
    gauge_cmd_t    next_beat;
    pace_t         pace = PACE_FULL;
    int            err_count = 0;
    int            idle_cycles = 0;

    // shadow of the configuration and needle state
    logic signed [15:0] cfg_min = 16'sd0;
    logic signed [15:0] cfg_max = 16'sd100;
    logic [15:0]        cfg_full = 16'd600;
    logic [15:0]        cfg_delay = 16'd1;
    logic [15:0]        cur_step = '0;
    logic [15:0]        tgt_step = '0;
    logic [15:0]        dly_cnt = '0;
    logic               homed_q = 1'b0;
    logic [3:0]         coil_q = '0;

    gauge_stepper_position_controller_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // user value to target step, rounded; empty range leaves the target alone
    function automatic void aim_needle(input longint req);
        longint span;
        longint steps;
        span = longint'(cfg_max) - longint'(cfg_min);
        if (span > 0) begin
            if (req < cfg_min) req = cfg_min;
            if (req > cfg_max) req = cfg_max;
            steps = ((req - cfg_min) * longint'(cfg_full) + span / 2) / span;
            if (steps > longint'(cfg_full)) steps = longint'(cfg_full);
            tgt_step = steps[15:0];
        end
    endfunction

    // advance the shadow state by one command and queue the report it yields
    function automatic void predict_command(input gspc_pkg::cmd_t cmd,
                                            input logic [15:0] value);
        logic          rejected;
        logic [1:0]    ph;
        longint        span;
        longint        q;
        gauge_report_t rep;
        rejected = 1'b0;
        case (cmd)
            gspc_pkg::CMD_TICK: begin
                if (tgt_step == cur_step) begin
                    dly_cnt = '0;
                    if (!homed_q) begin
                        homed_q = 1'b1;
                        tgt_step = '0;
                        cur_step = '0;
                    end
                end else if (dly_cnt != '0) begin
                    dly_cnt = dly_cnt - 16'd1;
                end else begin
                    if (tgt_step > cur_step) begin
                        ph = cur_step[1:0] + 2'd1;
                        coil_q = COIL_SEQ[ph * 4 +: 4];
                        if (cur_step >= cfg_full) cur_step = cfg_full;
                        else cur_step = cur_step + 16'd1;
                    end else begin
                        ph = cur_step[1:0] - 2'd1;
                        coil_q = COIL_SEQ[ph * 4 +: 4];
                        cur_step = cur_step - 16'd1;
                    end
                    dly_cnt = cfg_delay - 16'd1;
                end
            end
            gspc_pkg::CMD_SET_POS: begin
                if (!homed_q) rejected = 1'b1;
                else aim_needle(longint'($signed(value)));
            end
            gspc_pkg::CMD_STOP: begin
                tgt_step = cur_step;
            end
            default: begin
                coil_q = COIL_SEQ[3:0];
                cur_step = cfg_full;
                aim_needle(longint'(cfg_min));
            end
        endcase

        // readback with rounding, saturating past full travel
        span = longint'(cfg_max) - longint'(cfg_min);
        if (span <= 0) begin
            rep.position = cfg_min;
        end else begin
            q = (longint'(cur_step) * span + longint'(cfg_full) / 2) / longint'(cfg_full);
            rep.position = (q > span) ? cfg_max : 16'(q + longint'(cfg_min));
        end
        rep.coils = coil_q;
        rep.step_now = cur_step;
        rep.homed = homed_q;
        rep.moving = (tgt_step != cur_step);
        rep.ignored = rejected;
        report_q.push_back(rep);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            err_count++;
        end
    endfunction

    function automatic logic sender_rests();
        case (pace)
            PACE_SENDER_IDLE: return $urandom_range(99) < 78;
            PACE_BOTH:        return $urandom_range(99) < 11;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stalls();
        case (pace)
            PACE_RECEIVER_STALL: return $urandom_range(99) < 78;
            PACE_BOTH:           return $urandom_range(99) < 11;
            default:             return 1'b0;
        endcase
    endfunction

    // mostly near the configured range, some corners and some noise
    function automatic logic [15:0] pick_value();
        int lo;
        int hi;
        int v;
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return cfg_min;
                    default: return cfg_max;
                endcase
            end
            default: begin
                lo = int'(cfg_min) - 8;
                hi = int'(cfg_max) + 8;
                if (hi < lo) begin
                    v = lo;
                    lo = hi;
                    hi = v;
                end
                v = lo + int'($urandom_range(hi - lo));
                if (v < -32768) v = -32768;
                if (v > 32767) v = 32767;
                return 16'(v);
            end
        endcase
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_command(gspc_pkg::cmd_t'(s_tuser), s_tdata);
            if (!s_tvalid || s_tready) begin
                if (command_q.size() != 0 && !sender_rests()) begin
                    next_beat = command_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_beat.cmd;
                    s_tdata <= next_beat.value;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (report_q.size() == 0) begin
                    $error("result beat with no report pending: %h", m_tdata);
                    err_count++;
                end else begin
                    check_field("coils", report_q[0].coils, m_tdata[3:0]);
                    check_field("step_now", report_q[0].step_now, m_tdata[19:4]);
                    check_field("position", report_q[0].position, m_tdata[35:20]);
                    check_field("homed", report_q[0].homed, m_tdata[36]);
                    check_field("moving", report_q[0].moving, m_tdata[37]);
                    check_field("ignored", report_q[0].ignored, m_tdata[38]);
                    void'(report_q.pop_front());
                end
            end
            m_tready <= !receiver_stalls();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_cmd(input gspc_pkg::cmd_t c, input logic [15:0] v);
        command_q.push_back('{c, v});
    endtask

    // wait until every command is sent and every report has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (command_q.size() != 0 || s_tvalid || report_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input gspc_pkg::reg_idx_t idx, input logic [15:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            gspc_pkg::REG_MIN_VALUE:  cfg_min = data;
            gspc_pkg::REG_MAX_VALUE:  cfg_max = data;
            gspc_pkg::REG_FULL_STEPS: if (data != '0) cfg_full = data;
            default:                  cfg_delay = (data == '0) ? 16'd1 : data;
        endcase
    endtask

    // random commands, ticks dominate so the needle actually travels
    task automatic run_phase(input pace_t p, input int count);
        int             r;
        gspc_pkg::cmd_t c;
        pace = p;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 70) c = gspc_pkg::CMD_TICK;
            else if (r < 88) c = gspc_pkg::CMD_SET_POS;
            else if (r < 94) c = gspc_pkg::CMD_STOP;
            else c = gspc_pkg::CMD_HOME;
            push_cmd(c, pick_value());
        end
        wait_drained();
    endtask

    // stimulus sequencing
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset defaults, rejection before homing, homing, both directions
        pace = PACE_FULL;
        push_cmd(gspc_pkg::CMD_SET_POS, 16'd50);
        push_cmd(gspc_pkg::CMD_STOP, 16'($urandom));
        push_cmd(gspc_pkg::CMD_HOME, 16'($urandom));
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_SET_POS, 16'h7FFF);
        push_cmd(gspc_pkg::CMD_STOP, 16'($urandom));
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_SET_POS, 16'h7FFF);
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_SET_POS, 16'h8000);
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_SET_POS, 16'd1);
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_STOP, 16'($urandom));
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_HOME, 16'($urandom));
        push_cmd(gspc_pkg::CMD_SET_POS, 16'd100);
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        push_cmd(gspc_pkg::CMD_SET_POS, 16'hFFFF);
        push_cmd(gspc_pkg::CMD_TICK, 16'($urandom));
        wait_drained();

        // short travel centered on zero, sender paused halfway
        write_reg(gspc_pkg::REG_MIN_VALUE, 16'hFFCE);
        write_reg(gspc_pkg::REG_MAX_VALUE, 16'd50);
        write_reg(gspc_pkg::REG_FULL_STEPS, 16'd40);
        write_reg(gspc_pkg::REG_STEP_DELAY, 16'd1);
        run_phase(PACE_FULL, 75);
        run_phase(PACE_FULL, 75);
        push_cmd(gspc_pkg::CMD_HOME, 16'($urandom));
        wait_drained();

        // travel shortened under the needle, paced stepping
        write_reg(gspc_pkg::REG_FULL_STEPS, 16'd12);
        write_reg(gspc_pkg::REG_STEP_DELAY, 16'd3);
        run_phase(PACE_SENDER_IDLE, 110);

        // widest range and longest travel, zero delay reads as one
        write_reg(gspc_pkg::REG_MIN_VALUE, 16'h8000);
        write_reg(gspc_pkg::REG_MAX_VALUE, 16'h7FFF);
        write_reg(gspc_pkg::REG_FULL_STEPS, 16'hFFFF);
        write_reg(gspc_pkg::REG_STEP_DELAY, 16'h0000);
        run_phase(PACE_RECEIVER_STALL, 120);

        // empty ranges: equal bounds, then inverted bounds
        write_reg(gspc_pkg::REG_MIN_VALUE, 16'd10);
        write_reg(gspc_pkg::REG_MAX_VALUE, 16'd10);
        run_phase(PACE_BOTH, 40);
        write_reg(gspc_pkg::REG_MIN_VALUE, 16'd5);
        write_reg(gspc_pkg::REG_MAX_VALUE, 16'hFFFB);
        run_phase(PACE_BOTH, 40);

        // zero travel write is dropped, range of one, longest delay
        write_reg(gspc_pkg::REG_FULL_STEPS, 16'h0000);
        write_reg(gspc_pkg::REG_STEP_DELAY, 16'hFFFF);
        write_reg(gspc_pkg::REG_MIN_VALUE, 16'h8000);
        write_reg(gspc_pkg::REG_MAX_VALUE, 16'h8001);
        run_phase(PACE_BOTH, 60);

        // short travel over a wide user range
        write_reg(gspc_pkg::REG_MIN_VALUE, 16'hFF9C);
        write_reg(gspc_pkg::REG_MAX_VALUE, 16'd300);
        write_reg(gspc_pkg::REG_FULL_STEPS, 16'd3);
        write_reg(gspc_pkg::REG_STEP_DELAY, 16'd2);
        run_phase(PACE_RECEIVER_STALL, 110);

        write_reg(gspc_pkg::REG_MIN_VALUE, 16'd0);
        write_reg(gspc_pkg::REG_MAX_VALUE, 16'd100);
        write_reg(gspc_pkg::REG_FULL_STEPS, 16'd7);
        write_reg(gspc_pkg::REG_STEP_DELAY, 16'd1);
        run_phase(PACE_BOTH, 60);

        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
